@@ rtl/core/cdt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cdt_pkg: shared types, constants and functions of the date-time adder
// Holds the beat structs of both channels, the unit and error codes, the
// month length table and the divisor selection of the shared divider.
// ----------------------------------------------------------------------------
package cdt_pkg;

	// Width of the amount field.
	localparam int unsigned AMOUNT_WIDTH = 16;

	// Calendar constants.
	localparam int unsigned YEAR_MAX    = 65535;
	localparam int unsigned MONTHS      = 12;
	localparam int unsigned HOURS       = 24;
	localparam int unsigned MINUTES     = 60;
	localparam int unsigned LEAP_DAYS   = 29;
	localparam int unsigned FEBRUARY    = 2;
	localparam int unsigned DAYS_PER_4Y = 1461;

	// Widths of the four-year shortcut and of the divider remainder.
	localparam int unsigned QC_W      = 14;
	localparam int unsigned PROD_W    = 25;
	localparam int unsigned DIVISOR_W = 11;

	localparam logic [4:0] MONTH_DAYS [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic [2:0] {
		UNIT_YEAR   = 3'd0,
		UNIT_MONTH  = 3'd1,
		UNIT_DAY    = 3'd2,
		UNIT_HOUR   = 3'd3,
		UNIT_MINUTE = 3'd4
	} unit_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_ZERO = 2'd1,
		ERR_UNIT = 2'd2,
		ERR_OVF  = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		DIV_BY_12   = 2'd0,
		DIV_BY_24   = 2'd1,
		DIV_BY_60   = 2'd2,
		DIV_BY_1461 = 2'd3
	} div_sel_t;

	typedef struct packed {
		logic [15:0]             start_year;
		logic [3:0]              start_month;
		logic [4:0]              start_day;
		logic [4:0]              start_hour;
		logic [5:0]              start_minute;
		logic [2:0]              req_type;
		logic [AMOUNT_WIDTH-1:0] amount;
	} req_t;

	typedef struct packed {
		logic [15:0] new_year;
		logic [3:0]  new_month;
		logic [5:0]  new_day;
		logic [4:0]  new_hour;
		logic [5:0]  new_minute;
		logic [1:0]  error_code;
	} rsp_t;

	// Control from the sequencer to the divider.
	typedef struct packed {
		logic     start;
		div_sel_t sel;
	} div_ctl_t;

	// Status from the divider to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Length of a month; any month code outside January to December counts
	// as 31 days, and February is long in every year divisible by four.
	function automatic logic [4:0] month_len(input logic [3:0] mo, input logic [15:0] yr);
		logic [4:0] len;
		if (mo < 4'd1 || mo > 4'(MONTHS)) begin
			len = 5'd31;
		end else if (mo == 4'(FEBRUARY)) begin
			len = (yr[1:0] == 2'd0) ? 5'(LEAP_DAYS) : MONTH_DAYS[4'(FEBRUARY - 1)];
		end else begin
			len = MONTH_DAYS[4'(mo - 4'd1)];
		end
		return len;
	endfunction

	// Divisor value for a divider selection.
	function automatic logic [DIVISOR_W-1:0] div_value(input div_sel_t sel);
		logic [DIVISOR_W-1:0] val;
		case (sel)
			DIV_BY_12:   val = DIVISOR_W'(MONTHS);
			DIV_BY_24:   val = DIVISOR_W'(HOURS);
			DIV_BY_60:   val = DIVISOR_W'(MINUTES);
			default:     val = DIVISOR_W'(DAYS_PER_4Y);
		endcase
		return val;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/calendar_datetime_add_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_datetime_add_top: adds an amount of one unit to a date-time
// A small sequencer steps the calendar one month, one day run or one carry
// per cycle and shares one divider for all unit conversions.
// ----------------------------------------------------------------------------
// Flow: a zero amount or a bad unit goes straight to the result, years add
//   directly, and a divide runs first for months, hours, minutes and long day
//   amounts; day carries then step through the calendar month by month.
// Throughput: one beat at a time; req_ready is high only while idle, in the
//   cycle after the result is loaded, so no new beat is taken before then.
// Reset: arst_n clears the sequencer and the output register; no clearing pass.
module calendar_datetime_add_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cdt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cdt_pkg::rsp_t rsp
);

	localparam int unsigned AW     = cdt_pkg::AMOUNT_WIDTH;
	localparam int unsigned YSUM_W = ((AW > 16) ? AW : 16) + 1;
	localparam int unsigned CMP_W  = (AW > cdt_pkg::QC_W) ? AW : cdt_pkg::QC_W;
	localparam int unsigned QC_W   = cdt_pkg::QC_W;
	localparam int unsigned PROD_W = cdt_pkg::PROD_W;
	localparam int unsigned DW     = cdt_pkg::DIVISOR_W;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_YEAR,
		ST_MON_DIV,
		ST_MON_ADD,
		ST_DAY_CHK,
		ST_DAY_DIV,
		ST_DAY_MUL,
		ST_DAY_SUB,
		ST_DLOOP,
		ST_DFIN,
		ST_HR_DIV,
		ST_HFIN,
		ST_MIN_DIV,
		ST_MFIN,
		ST_AH0,
		ST_AH1,
		ST_AH_DIV,
		ST_ADAYS,
		ST_DONE
	} state_t;

	state_t                state_q;
	state_t                dret_q;
	state_t                hret_q;
	cdt_pkg::req_t         in_q;
	cdt_pkg::err_t         err_q;
	logic [15:0]           y_q;
	logic [3:0]            mo_q;
	logic [5:0]            d_q;
	logic [4:0]            h_q;
	logic [5:0]            mi_q;
	logic [AW-1:0]         k_q;
	logic [AW-1:0]         hk_q;
	logic [DW-1:0]         rem_q;
	logic [5:0]            mrem_q;
	logic [QC_W-1:0]       qc_q;
	logic [PROD_W-1:0]     prod_q;
	logic                  div_start_q;
	cdt_pkg::div_sel_t     div_sel_q;
	logic [AW-1:0]         div_arg_q;
	cdt_pkg::rsp_t         rsp_q;
	logic                  rsp_valid_q;

	cdt_pkg::div_ctl_t     div_ctl;
	cdt_pkg::div_stat_t    div_stat;
	logic [AW-1:0]         div_quot;
	logic [DW-1:0]         div_rem;

	logic [AW-1:0]         amt_c;
	logic [4:0]            ml_c;
	logic                  mo_wrap_c;
	logic [3:0]            inc_mo_c;
	logic [15:0]           inc_y_c;
	logic                  inc_ovf_c;
	logic [YSUM_W-1:0]     ysum_amt_c;
	logic [YSUM_W-1:0]     ysum_quot_c;
	logic [QC_W-1:0]       qmax_c;
	logic                  q_big_c;
	logic [QC_W-1:0]       qc_c;
	logic [3:0]            nm_c;
	logic [4:0]            mosum_c;
	logic [5:0]            dsum_c;
	logic [4:0]            room_c;
	logic [5:0]            hsum_c;
	logic [6:0]            misum_c;

	// Shared divider.
	assign div_ctl.start = div_start_q;
	assign div_ctl.sel   = div_sel_q;

	cdt_div #(
		.DIV_WIDTH(AW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_arg_q),
		.stat     (div_stat),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	// Month length and the single month step with its year carry.
	assign amt_c     = in_q.amount;
	assign ml_c      = cdt_pkg::month_len(mo_q, y_q);
	assign mo_wrap_c = (mo_q >= 4'(cdt_pkg::MONTHS));
	assign inc_mo_c  = mo_wrap_c ? 4'd1 : mo_q + 4'd1;
	assign inc_y_c   = mo_wrap_c ? y_q + 16'd1 : y_q;
	assign inc_ovf_c = mo_wrap_c && (y_q == 16'(cdt_pkg::YEAR_MAX));

	// Year sums with overflow headroom.
	assign ysum_amt_c  = YSUM_W'(y_q) + YSUM_W'(amt_c);
	assign ysum_quot_c = YSUM_W'(y_q) + YSUM_W'(div_quot);

	// Four-year shortcut, limited so that the year cannot pass its maximum.
	assign qmax_c  = QC_W'((16'(cdt_pkg::YEAR_MAX) - y_q) >> 2);
	assign q_big_c = (CMP_W'(div_quot) > CMP_W'(qmax_c));
	assign qc_c    = q_big_c ? qmax_c : QC_W'(div_quot);

	// Remainder adds of the months, days, hours and minutes.
	assign nm_c    = rem_q[3:0] + 4'd1;
	assign mosum_c = {1'b0, mo_q} + {1'b0, nm_c};
	assign dsum_c  = d_q + {1'b0, k_q[4:0]};
	assign room_c  = ml_c - d_q[4:0];
	assign hsum_c  = {1'b0, h_q} + {1'b0, rem_q[4:0]};
	assign misum_c = {1'b0, mi_q} + {1'b0, mrem_q};

	// Sequencer, working registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dret_q      <= ST_DONE;
			hret_q      <= ST_DONE;
			in_q        <= '0;
			err_q       <= cdt_pkg::ERR_NONE;
			y_q         <= '0;
			mo_q        <= '0;
			d_q         <= '0;
			h_q         <= '0;
			mi_q        <= '0;
			k_q         <= '0;
			hk_q        <= '0;
			rem_q       <= '0;
			mrem_q      <= '0;
			qc_q        <= '0;
			prod_q      <= '0;
			div_start_q <= 1'b0;
			div_sel_q   <= cdt_pkg::DIV_BY_12;
			div_arg_q   <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						in_q    <= req;
						y_q     <= req.start_year;
						mo_q    <= req.start_month;
						d_q     <= {1'b0, req.start_day};
						h_q     <= req.start_hour;
						mi_q    <= req.start_minute;
						err_q   <= cdt_pkg::ERR_NONE;
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					if (amt_c == '0) begin
						err_q   <= cdt_pkg::ERR_ZERO;
						state_q <= ST_DONE;
					end else begin
						case (cdt_pkg::unit_t'(in_q.req_type))
							cdt_pkg::UNIT_YEAR: begin
								state_q <= ST_YEAR;
							end
							cdt_pkg::UNIT_MONTH: begin
								div_start_q <= 1'b1;
								div_sel_q   <= cdt_pkg::DIV_BY_12;
								div_arg_q   <= amt_c - AW'(1);
								state_q     <= ST_MON_DIV;
							end
							cdt_pkg::UNIT_DAY: begin
								state_q <= ST_DAY_CHK;
							end
							cdt_pkg::UNIT_HOUR: begin
								div_start_q <= 1'b1;
								div_sel_q   <= cdt_pkg::DIV_BY_24;
								div_arg_q   <= amt_c;
								state_q     <= ST_HR_DIV;
							end
							cdt_pkg::UNIT_MINUTE: begin
								div_start_q <= 1'b1;
								div_sel_q   <= cdt_pkg::DIV_BY_60;
								div_arg_q   <= amt_c;
								state_q     <= ST_MIN_DIV;
							end
							default: begin
								err_q   <= cdt_pkg::ERR_UNIT;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				// Whole years add directly.
				ST_YEAR: begin
					if (ysum_amt_c > YSUM_W'(cdt_pkg::YEAR_MAX)) begin
						err_q <= cdt_pkg::ERR_OVF;
					end else begin
						y_q <= ysum_amt_c[15:0];
					end
					state_q <= ST_DONE;
				end
				// Months: whole years first, then the remaining 1 to 12 months.
				ST_MON_DIV: begin
					if (div_stat.done) begin
						if (ysum_quot_c > YSUM_W'(cdt_pkg::YEAR_MAX)) begin
							err_q   <= cdt_pkg::ERR_OVF;
							state_q <= ST_DONE;
						end else begin
							y_q     <= ysum_quot_c[15:0];
							rem_q   <= div_rem;
							state_q <= ST_MON_ADD;
						end
					end
				end
				ST_MON_ADD: begin
					if (mosum_c > 5'(cdt_pkg::MONTHS)) begin
						mo_q <= 4'(mosum_c - 5'(cdt_pkg::MONTHS));
						if (y_q == 16'(cdt_pkg::YEAR_MAX)) begin
							err_q <= cdt_pkg::ERR_OVF;
						end else begin
							y_q <= y_q + 16'd1;
						end
					end else begin
						mo_q <= mosum_c[3:0];
					end
					state_q <= ST_DONE;
				end
				// Days: skip whole four-year spans for a valid month and an amount over 1461.
				ST_DAY_CHK: begin
					if (mo_q >= 4'd1 && mo_q <= 4'(cdt_pkg::MONTHS) &&
					    32'(amt_c) > cdt_pkg::DAYS_PER_4Y) begin
						div_start_q <= 1'b1;
						div_sel_q   <= cdt_pkg::DIV_BY_1461;
						div_arg_q   <= amt_c - AW'(1);
						state_q     <= ST_DAY_DIV;
					end else begin
						k_q     <= amt_c;
						state_q <= ST_DLOOP;
					end
				end
				ST_DAY_DIV: begin
					if (div_stat.done) begin
						qc_q <= qc_c;
						y_q  <= y_q + 16'({qc_c, 2'b00});
						if (q_big_c) begin
							state_q <= ST_DAY_MUL;
						end else begin
							k_q     <= AW'(div_rem) + AW'(1);
							state_q <= ST_DLOOP;
						end
					end
				end
				ST_DAY_MUL: begin
					prod_q  <= PROD_W'(qc_q) * PROD_W'(cdt_pkg::DAYS_PER_4Y);
					state_q <= ST_DAY_SUB;
				end
				ST_DAY_SUB: begin
					k_q     <= amt_c - AW'(prod_q);
					state_q <= ST_DLOOP;
				end
				// Take off whole months while the amount exceeds this month.
				ST_DLOOP: begin
					if (k_q <= AW'(ml_c)) begin
						state_q <= ST_DFIN;
					end else if (inc_ovf_c) begin
						err_q   <= cdt_pkg::ERR_OVF;
						state_q <= ST_DONE;
					end else begin
						k_q  <= k_q - AW'(ml_c);
						mo_q <= inc_mo_c;
						y_q  <= inc_y_c;
					end
				end
				ST_DFIN: begin
					if (dsum_c > {1'b0, ml_c}) begin
						d_q <= dsum_c - {1'b0, ml_c};
						if (inc_ovf_c) begin
							err_q <= cdt_pkg::ERR_OVF;
						end else begin
							mo_q <= inc_mo_c;
							y_q  <= inc_y_c;
						end
					end else begin
						d_q <= dsum_c;
					end
					state_q <= ST_DONE;
				end
				// Hours: whole days, then the remaining hours with one carry.
				ST_HR_DIV: begin
					if (div_stat.done) begin
						k_q     <= div_quot;
						rem_q   <= div_rem;
						dret_q  <= ST_HFIN;
						state_q <= ST_ADAYS;
					end
				end
				ST_HFIN: begin
					if (hsum_c > 6'(cdt_pkg::HOURS - 1)) begin
						h_q     <= 5'(hsum_c - 6'(cdt_pkg::HOURS));
						k_q     <= AW'(1);
						dret_q  <= ST_DONE;
						state_q <= ST_ADAYS;
					end else begin
						h_q     <= hsum_c[4:0];
						state_q <= ST_DONE;
					end
				end
				// Minutes: whole hours, then the remaining minutes with one carry.
				ST_MIN_DIV: begin
					if (div_stat.done) begin
						hk_q    <= div_quot;
						mrem_q  <= div_rem[5:0];
						hret_q  <= ST_MFIN;
						state_q <= ST_AH0;
					end
				end
				ST_MFIN: begin
					if (misum_c > 7'(cdt_pkg::MINUTES - 1)) begin
						mi_q    <= 6'(misum_c - 7'(cdt_pkg::MINUTES));
						hk_q    <= AW'(1);
						hret_q  <= ST_DONE;
						state_q <= ST_AH0;
					end else begin
						mi_q    <= misum_c[5:0];
						state_q <= ST_DONE;
					end
				end
				// Hour carry: an out-of-range hour first rolls into a new day.
				ST_AH0: begin
					if (hk_q == '0) begin
						state_q <= hret_q;
					end else if (h_q > 5'(cdt_pkg::HOURS - 1)) begin
						h_q     <= '0;
						hk_q    <= hk_q - AW'(1);
						k_q     <= AW'(1);
						dret_q  <= ST_AH1;
						state_q <= ST_ADAYS;
					end else begin
						state_q <= ST_AH1;
					end
				end
				ST_AH1: begin
					div_start_q <= 1'b1;
					div_sel_q   <= cdt_pkg::DIV_BY_24;
					div_arg_q   <= AW'(h_q) + hk_q;
					state_q     <= ST_AH_DIV;
				end
				ST_AH_DIV: begin
					if (div_stat.done) begin
						h_q     <= div_rem[4:0];
						k_q     <= div_quot;
						dret_q  <= hret_q;
						state_q <= ST_ADAYS;
					end
				end
				// Day carry: fill the current month or roll to the next one.
				ST_ADAYS: begin
					if (k_q == '0) begin
						state_q <= dret_q;
					end else if ((d_q + 6'd1) > {1'b0, ml_c}) begin
						if (inc_ovf_c) begin
							err_q   <= cdt_pkg::ERR_OVF;
							state_q <= ST_DONE;
						end else begin
							d_q  <= 6'd1;
							k_q  <= k_q - AW'(1);
							mo_q <= inc_mo_c;
							y_q  <= inc_y_c;
						end
					end else if (k_q < AW'(room_c)) begin
						d_q <= d_q + {1'b0, k_q[4:0]};
						k_q <= '0;
					end else begin
						d_q <= d_q + {1'b0, room_c};
						k_q <= k_q - AW'(room_c);
					end
				end
				// Hand the result to the output register once it is free.
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						if (err_q != cdt_pkg::ERR_NONE) begin
							rsp_q.new_year   <= in_q.start_year;
							rsp_q.new_month  <= in_q.start_month;
							rsp_q.new_day    <= {1'b0, in_q.start_day};
							rsp_q.new_hour   <= in_q.start_hour;
							rsp_q.new_minute <= in_q.start_minute;
						end else begin
							rsp_q.new_year   <= y_q;
							rsp_q.new_month  <= mo_q;
							rsp_q.new_day    <= d_q;
							rsp_q.new_hour   <= h_q;
							rsp_q.new_minute <= mi_q;
						end
						rsp_q.error_code <= err_q;
						rsp_valid_q      <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// One beat at a time: no second beat right after an accepted one.
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second beat accepted while busy");

	// The divider finishes only while the sequencer waits for it.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_MON_DIV || state_q == ST_DAY_DIV ||
		                   state_q == ST_HR_DIV || state_q == ST_MIN_DIV ||
		                   state_q == ST_AH_DIV))
		else $error("divider result arrived outside a wait state");

	// The month stepper always has at least one day left to place.
	a_days_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DLOOP |-> k_q != '0)
		else $error("month stepper entered with no days");

endmodule
`default_nettype wire

@@ rtl/core/cdt_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cdt_div: divider by a selectable calendar constant
// Multiplies the dividend by a rounded-up reciprocal of 12, 24, 60 or 1461,
// takes the quotient from the upper product bits and forms the remainder by
// a multiply and subtract. The result is ready when done pulses after the remainder.
// ----------------------------------------------------------------------------
module cdt_div #(
	parameter int unsigned DIV_WIDTH = cdt_pkg::AMOUNT_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cdt_pkg::div_ctl_t                ctl,
	input  logic [DIV_WIDTH-1:0]             dividend,
	output cdt_pkg::div_stat_t               stat,
	output logic [DIV_WIDTH-1:0]             quotient,
	output logic [cdt_pkg::DIVISOR_W-1:0]    remainder
);

	localparam int unsigned DW = cdt_pkg::DIVISOR_W;
	localparam int unsigned RW = DIV_WIDTH + 1;
	localparam int unsigned PW = DIV_WIDTH + RW;
	localparam int unsigned BW = DIV_WIDTH + DW;

	// A shift of the dividend width plus the divisor's bit length keeps the
	// rounded-up reciprocal exact for every dividend.
	localparam int unsigned SH_12   = DIV_WIDTH + $clog2(cdt_pkg::MONTHS);
	localparam int unsigned SH_24   = DIV_WIDTH + $clog2(cdt_pkg::HOURS);
	localparam int unsigned SH_60   = DIV_WIDTH + $clog2(cdt_pkg::MINUTES);
	localparam int unsigned SH_1461 = DIV_WIDTH + $clog2(cdt_pkg::DAYS_PER_4Y);
	localparam longint unsigned REC_12 =
		((64'd1 << SH_12) + 64'(cdt_pkg::MONTHS) - 64'd1) / 64'(cdt_pkg::MONTHS);
	localparam longint unsigned REC_24 =
		((64'd1 << SH_24) + 64'(cdt_pkg::HOURS) - 64'd1) / 64'(cdt_pkg::HOURS);
	localparam longint unsigned REC_60 =
		((64'd1 << SH_60) + 64'(cdt_pkg::MINUTES) - 64'd1) / 64'(cdt_pkg::MINUTES);
	localparam longint unsigned REC_1461 =
		((64'd1 << SH_1461) + 64'(cdt_pkg::DAYS_PER_4Y) - 64'd1) /
		64'(cdt_pkg::DAYS_PER_4Y);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_MUL,
		PH_SHIFT,
		PH_REM
	} phase_t;

	phase_t               phase_q;
	logic                 done_q;
	cdt_pkg::div_sel_t    sel_q;
	logic [DIV_WIDTH-1:0] arg_q;
	logic [PW-1:0]        prod_q;
	logic [DIV_WIDTH-1:0] quot_q;
	logic [DW-1:0]        rem_q;
	logic [RW-1:0]        recip_c;
	logic [DIV_WIDTH-1:0] quot_c;
	logic [DW-1:0]        divisor_c;
	logic [BW-1:0]        back_c;

	// Reciprocal and quotient extraction for the selected divisor.
	always_comb begin
		case (sel_q)
			cdt_pkg::DIV_BY_12: begin
				recip_c = RW'(REC_12);
				quot_c  = DIV_WIDTH'(prod_q >> SH_12);
			end
			cdt_pkg::DIV_BY_24: begin
				recip_c = RW'(REC_24);
				quot_c  = DIV_WIDTH'(prod_q >> SH_24);
			end
			cdt_pkg::DIV_BY_60: begin
				recip_c = RW'(REC_60);
				quot_c  = DIV_WIDTH'(prod_q >> SH_60);
			end
			default: begin
				recip_c = RW'(REC_1461);
				quot_c  = DIV_WIDTH'(prod_q >> SH_1461);
			end
		endcase
	end

	// Quotient times divisor, taken off the dividend for the remainder.
	assign divisor_c = cdt_pkg::div_value(sel_q);
	assign back_c    = BW'(quot_q) * BW'(divisor_c);

	// Multiply, extract the quotient, then form the remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
			sel_q   <= cdt_pkg::DIV_BY_12;
			arg_q   <= '0;
			prod_q  <= '0;
			quot_q  <= '0;
			rem_q   <= '0;
		end else begin
			if (ctl.start) begin
				phase_q <= PH_MUL;
				done_q  <= 1'b0;
				sel_q   <= ctl.sel;
				arg_q   <= dividend;
			end else begin
				case (phase_q)
					PH_MUL: begin
						prod_q  <= PW'(arg_q) * PW'(recip_c);
						phase_q <= PH_SHIFT;
						done_q  <= 1'b0;
					end
					PH_SHIFT: begin
						quot_q  <= quot_c;
						phase_q <= PH_REM;
						done_q  <= 1'b0;
					end
					PH_REM: begin
						rem_q   <= DW'(arg_q - back_c[DIV_WIDTH-1:0]);
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end
					default: begin
						done_q <= 1'b0;
					end
				endcase
			end
		end
	end

	assign stat.busy = (phase_q != PH_IDLE);
	assign stat.done = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;

	// A start always leads into a busy phase.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> (phase_q != PH_IDLE))
		else $error("divider did not go busy after start");

	// The done pulse comes only after the busy phase has ended.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (phase_q == PH_IDLE))
		else $error("divider done while still busy");

	// The remainder always stays below the divisor.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < divisor_c))
		else $error("divider remainder out of range");

	// Quotient and remainder rebuild the dividend exactly.
	a_exact: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ((back_c + BW'(rem_q)) == BW'(arg_q)))
		else $error("divider quotient is not exact");

endmodule
`default_nettype wire

@@ tb/tb_calendar_datetime_add_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_datetime_add_top: self-checking bench of the date-time adder
// Drives request beats from a short directed table and then from random
// traffic, predicts untyped results with a behavioral calendar model, and
// compares each result beat field by field. Sender gaps, receiver stalls and
// one long receiver hold-off vary the timing across four phases.
// ----------------------------------------------------------------------------
module tb_calendar_datetime_add_top;
	import cdt_pkg::*;

	// Calendar limits used by the predictor.
	localparam longint unsigned YEAR_LAST   = 65535;
	localparam longint unsigned YEAR_MONTHS = 12;
	localparam longint unsigned DAY_HOURS   = 24;
	localparam longint unsigned HOUR_MINS   = 60;
	localparam longint unsigned QUAD_DAYS   = 1461;
	localparam int unsigned MONTH_LENGTHS [12] = '{
		31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
	};

	// Unit codes past the last valid one.
	localparam logic [2:0] UNIT_BAD_LO = 3'(UNIT_MINUTE + 1);
	localparam logic [2:0] UNIT_BAD_HI = 3'b111;

	// Run control.
	localparam int unsigned ITEMS_PER_PHASE = 62;
	localparam int unsigned HOLD_CYCLES     = 400;
	localparam int unsigned DRAIN_LIMIT     = 20000;
	localparam int unsigned SETTLE_CYCLES   = 40;
	localparam int unsigned TIMEOUT_NS      = 6_000_000;

	// Working copy of a date-time while carries ripple through it.
	typedef struct packed {
		bit [31:0] y;
		bit [31:0] mo;
		bit [31:0] d;
		bit [31:0] h;
		bit [31:0] mi;
		bit        ovf;
	} cal_t;

	// One row of the directed table; want is used only where typed is set.
	typedef struct packed {
		req_t stim;
		logic typed;
		rsp_t want;
	} vector_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req       = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;

	rsp_t        expected_dates [$];
	rsp_t        head_date;
	vector_row_t directed_rows [$];
	int unsigned mismatch_count = 0;
	int unsigned idle_pct       = 0;
	int unsigned stall_pct      = 0;
	bit          hold_request   = 1'b0;
	bit          hold_taken     = 1'b0;
	int unsigned hold_left      = 0;

	calendar_datetime_add_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Ends the run if the traffic never completes.
	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

	// Prints one line per fault and counts it.
	task automatic report_fault(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// Length of the current month; codes outside 1..12 count as 31 days.
	function automatic bit [31:0] days_of(input cal_t c);
		if (c.mo < 1 || c.mo > YEAR_MONTHS) return 31;
		if (c.mo == 2) return (c.y % 4 == 0) ? 29 : 28;
		return MONTH_LENGTHS[c.mo - 1];
	endfunction

	// Adds whole years and flags a pass beyond the last year.
	function automatic cal_t add_years(input cal_t c, input longint unsigned k);
		if (c.ovf) return c;
		if (64'(c.y) + k > YEAR_LAST) c.ovf = 1'b1;
		else c.y = c.y + 32'(k);
		return c;
	endfunction

	// Single month step with a year carry after December.
	function automatic cal_t next_month(input cal_t c);
		if (c.mo + 1 > YEAR_MONTHS) begin
			c.mo = 1;
			c = add_years(c, 1);
		end else begin
			c.mo = c.mo + 1;
		end
		return c;
	endfunction

	// Day carry used by the hour and minute paths: fill the month, then
	// restart at day one of the next month.
	function automatic cal_t carry_days(input cal_t c, input longint unsigned k);
		bit [31:0]       ml;
		longint unsigned room;
		longint unsigned step;
		while (k > 0 && !c.ovf) begin
			ml = days_of(c);
			if (c.d + 1 > ml) begin
				c.d = 1;
				c = next_month(c);
				k--;
			end else begin
				room = 64'(ml - c.d);
				step = (k < room) ? k : room;
				c.d = c.d + 32'(step);
				k -= step;
			end
		end
		return c;
	endfunction

	// Hour carry used by the minute path; an out-of-range hour first rolls
	// over to midnight of the next day.
	function automatic cal_t carry_hours(input cal_t c, input longint unsigned k);
		longint unsigned total;
		if (k == 0 || c.ovf) return c;
		if (c.h > DAY_HOURS - 1) begin
			c.h = 0;
			c = carry_days(c, 1);
			k--;
		end
		total = 64'(c.h) + k;
		c.h = 32'(total % DAY_HOURS);
		c = carry_days(c, total / DAY_HOURS);
		return c;
	endfunction

	// Expected result beat for one request beat.
	function automatic rsp_t advance_datetime(input req_t r);
		cal_t            c;
		longint unsigned n;
		longint unsigned q;
		longint unsigned qmax;
		bit [31:0]       ml;
		err_t            code;
		rsp_t            o;
		c.y   = 32'(r.start_year);
		c.mo  = 32'(r.start_month);
		c.d   = 32'(r.start_day);
		c.h   = 32'(r.start_hour);
		c.mi  = 32'(r.start_minute);
		c.ovf = 1'b0;
		n     = 64'(r.amount);
		code  = ERR_NONE;
		if (n == 0) begin
			code = ERR_ZERO;
		end else if (r.req_type > UNIT_MINUTE) begin
			code = ERR_UNIT;
		end else begin
			case (r.req_type)
				UNIT_YEAR: begin
					c = add_years(c, n);
				end
				UNIT_MONTH: begin
					// Whole years first, then at most one year carry.
					q = (n - 1) / YEAR_MONTHS;
					n -= q * YEAR_MONTHS;
					c = add_years(c, q);
					if (64'(c.mo) + n > YEAR_MONTHS) begin
						c.mo = 32'(64'(c.mo) + n - YEAR_MONTHS);
						c = add_years(c, 1);
					end else begin
						c.mo = c.mo + 32'(n);
					end
				end
				UNIT_DAY: begin
					// Four-year blocks of fixed length, capped at the last year.
					if (c.mo >= 1 && c.mo <= YEAR_MONTHS && n > QUAD_DAYS) begin
						q    = (n - 1) / QUAD_DAYS;
						qmax = (YEAR_LAST - 64'(c.y)) / 4;
						if (q > qmax) q = qmax;
						n -= q * QUAD_DAYS;
						c.y = c.y + 32'(q * 4);
					end
					// Whole months while the amount exceeds the current one.
					while (!c.ovf && n > 64'(days_of(c))) begin
						n -= 64'(days_of(c));
						c = next_month(c);
					end
					if (!c.ovf) begin
						ml = days_of(c);
						if (64'(c.d) + n > 64'(ml)) begin
							c.d = 32'(64'(c.d) + n - 64'(ml));
							c = next_month(c);
						end else begin
							c.d = c.d + 32'(n);
						end
					end
				end
				UNIT_HOUR: begin
					c = carry_days(c, n / DAY_HOURS);
					n = n % DAY_HOURS;
					if (!c.ovf) begin
						if (64'(c.h) + n > DAY_HOURS - 1) begin
							c.h = 32'(64'(c.h) + n - DAY_HOURS);
							c = carry_days(c, 1);
						end else begin
							c.h = c.h + 32'(n);
						end
					end
				end
				default: begin
					c = carry_hours(c, n / HOUR_MINS);
					n = n % HOUR_MINS;
					if (!c.ovf) begin
						if (64'(c.mi) + n > HOUR_MINS - 1) begin
							c.mi = 32'(64'(c.mi) + n - HOUR_MINS);
							c = carry_hours(c, 1);
						end else begin
							c.mi = c.mi + 32'(n);
						end
					end
				end
			endcase
			if (c.ovf) code = ERR_OVF;
		end
		// Any error echoes the starting date-time.
		if (code != ERR_NONE) begin
			o.new_year   = r.start_year;
			o.new_month  = r.start_month;
			o.new_day    = 6'(r.start_day);
			o.new_hour   = r.start_hour;
			o.new_minute = r.start_minute;
		end else begin
			o.new_year   = c.y[15:0];
			o.new_month  = c.mo[3:0];
			o.new_day    = c.d[5:0];
			o.new_hour   = c.h[4:0];
			o.new_minute = c.mi[5:0];
		end
		o.error_code = code;
		return o;
	endfunction

	function automatic req_t make_req(input int unsigned y, input int unsigned mo,
			input int unsigned d, input int unsigned h, input int unsigned mi,
			input logic [2:0] unit, input int unsigned amt);
		req_t r;
		r.start_year   = 16'(y);
		r.start_month  = 4'(mo);
		r.start_day    = 5'(d);
		r.start_hour   = 5'(h);
		r.start_minute = 6'(mi);
		r.req_type     = unit;
		r.amount       = AMOUNT_WIDTH'(amt);
		return r;
	endfunction

	function automatic rsp_t make_rsp(input int unsigned y, input int unsigned mo,
			input int unsigned d, input int unsigned h, input int unsigned mi,
			input err_t code);
		rsp_t o;
		o.new_year   = 16'(y);
		o.new_month  = 4'(mo);
		o.new_day    = 6'(d);
		o.new_hour   = 5'(h);
		o.new_minute = 6'(mi);
		o.error_code = code;
		return o;
	endfunction

	task automatic add_row(input req_t stim, input logic typed, input rsp_t want);
		vector_row_t row;
		row.stim  = stim;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endtask

	// Mostly well-formed dates with random content; the rest is raw noise
	// over the full width of every field.
	function automatic req_t random_request();
		req_t        r;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 12) begin
			r.start_year   = 16'($urandom);
			r.start_month  = 4'($urandom);
			r.start_day    = 5'($urandom);
			r.start_hour   = 5'($urandom);
			r.start_minute = 6'($urandom);
			r.req_type     = 3'($urandom);
			r.amount       = AMOUNT_WIDTH'($urandom);
			return r;
		end
		pick = $urandom_range(99);
		if (pick < 5) r.start_year = '0;
		else if (pick < 15) r.start_year = 16'($urandom_range(65535, 65500));
		else r.start_year = 16'($urandom);
		r.start_month  = 4'($urandom_range(12, 1));
		r.start_day    = 5'($urandom_range(31, 1));
		r.start_hour   = 5'($urandom_range(23));
		r.start_minute = 6'($urandom_range(59));
		pick = $urandom_range(99);
		if (pick < 4) r.req_type = 3'($urandom_range(UNIT_BAD_HI, UNIT_BAD_LO));
		else r.req_type = 3'($urandom_range(int'(UNIT_MINUTE)));
		pick = $urandom_range(99);
		if (pick < 3) r.amount = '0;
		else if (pick < 33) r.amount = AMOUNT_WIDTH'($urandom_range(3, 1));
		else if (pick < 63) r.amount = AMOUNT_WIDTH'($urandom_range(100, 1));
		else if (pick < 83) r.amount = AMOUNT_WIDTH'($urandom_range(5000, 1));
		else r.amount = AMOUNT_WIDTH'($urandom_range(65535, 1));
		return r;
	endfunction

	// Offers one beat after an optional gap and records its expected result
	// once it is taken.
	task automatic send_req(input req_t r, input logic typed, input rsp_t want);
		if ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		expected_dates.push_back(typed ? want : advance_datetime(r));
	endtask

	// Receiver: random stalls, plus one long hold-off when requested.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_taken) begin
			rsp_ready  <= 1'b0;
			hold_left  <= HOLD_CYCLES;
			hold_taken <= 1'b1;
		end else begin
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Result checker: each accepted beat against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_dates.size() == 0) begin
				report_fault($sformatf("result beat %h with nothing expected", rsp));
			end else begin
				head_date = expected_dates.pop_front();
				if (rsp.new_year !== head_date.new_year)
					report_fault($sformatf("new_year got %0d expected %0d",
						rsp.new_year, head_date.new_year));
				if (rsp.new_month !== head_date.new_month)
					report_fault($sformatf("new_month got %0d expected %0d",
						rsp.new_month, head_date.new_month));
				if (rsp.new_day !== head_date.new_day)
					report_fault($sformatf("new_day got %0d expected %0d",
						rsp.new_day, head_date.new_day));
				if (rsp.new_hour !== head_date.new_hour)
					report_fault($sformatf("new_hour got %0d expected %0d",
						rsp.new_hour, head_date.new_hour));
				if (rsp.new_minute !== head_date.new_minute)
					report_fault($sformatf("new_minute got %0d expected %0d",
						rsp.new_minute, head_date.new_minute));
				if (rsp.error_code !== head_date.error_code)
					report_fault($sformatf("error_code got %0d expected %0d",
						rsp.error_code, head_date.error_code));
			end
		end
	end

	// Main sequence: reset, directed table, four random phases, drain.
	initial begin
		int unsigned phase;
		int unsigned i;
		int unsigned drain_wait;

		// Directed table: typed rows are plain calendar facts and error codes.
		add_row(make_req(2023, 3, 15, 10, 30, UNIT_YEAR, 1), 1'b1,
			make_rsp(2024, 3, 15, 10, 30, ERR_NONE));
		add_row(make_req(65535, 6, 1, 0, 0, UNIT_YEAR, 1), 1'b1,
			make_rsp(65535, 6, 1, 0, 0, ERR_OVF));
		add_row(make_req(0, 1, 1, 0, 0, UNIT_YEAR, 65535), 1'b1,
			make_rsp(65535, 1, 1, 0, 0, ERR_NONE));
		add_row(make_req(2000, 5, 5, 5, 5, UNIT_BAD_HI, 0), 1'b1,
			make_rsp(2000, 5, 5, 5, 5, ERR_ZERO));
		add_row(make_req(2000, 5, 5, 5, 5, UNIT_BAD_LO, 1), 1'b1,
			make_rsp(2000, 5, 5, 5, 5, ERR_UNIT));
		add_row(make_req(2000, 5, 5, 5, 5, UNIT_BAD_HI, 65535), 1'b1,
			make_rsp(2000, 5, 5, 5, 5, ERR_UNIT));
		add_row(make_req(2023, 11, 30, 8, 0, UNIT_MONTH, 2), 1'b1,
			make_rsp(2024, 1, 30, 8, 0, ERR_NONE));
		add_row(make_req(2024, 2, 28, 0, 0, UNIT_DAY, 1), 1'b1,
			make_rsp(2024, 2, 29, 0, 0, ERR_NONE));
		add_row(make_req(2023, 2, 28, 0, 0, UNIT_DAY, 1), 1'b1,
			make_rsp(2023, 3, 1, 0, 0, ERR_NONE));
		add_row(make_req(0, 2, 28, 0, 0, UNIT_DAY, 1), 1'b1,
			make_rsp(0, 2, 29, 0, 0, ERR_NONE));
		add_row(make_req(65535, 12, 31, 12, 0, UNIT_DAY, 1), 1'b1,
			make_rsp(65535, 12, 31, 12, 0, ERR_OVF));
		add_row(make_req(2023, 6, 30, 23, 0, UNIT_HOUR, 1), 1'b1,
			make_rsp(2023, 7, 1, 0, 0, ERR_NONE));
		add_row(make_req(2023, 6, 10, 12, 59, UNIT_MINUTE, 1), 1'b1,
			make_rsp(2023, 6, 10, 13, 0, ERR_NONE));
		add_row(make_req(65535, 12, 31, 23, 59, UNIT_MINUTE, 1), 1'b1,
			make_rsp(65535, 12, 31, 23, 59, ERR_OVF));
		// Rows left to the predictor: long carries and out-of-range fields.
		add_row(make_req(0, 1, 1, 0, 0, UNIT_MONTH, 65535), 1'b0, '0);
		add_row(make_req(100, 15, 3, 0, 0, UNIT_MONTH, 5), 1'b0, '0);
		add_row(make_req(0, 1, 1, 0, 0, UNIT_DAY, 65535), 1'b0, '0);
		add_row(make_req(400, 13, 10, 0, 0, UNIT_DAY, 1000), 1'b0, '0);
		add_row(make_req(2021, 7, 0, 0, 0, UNIT_DAY, 1), 1'b0, '0);
		add_row(make_req(2023, 4, 31, 0, 0, UNIT_DAY, 1), 1'b0, '0);
		add_row(make_req(2023, 9, 15, 31, 0, UNIT_HOUR, 23), 1'b0, '0);
		add_row(make_req(1999, 12, 31, 23, 0, UNIT_HOUR, 65535), 1'b0, '0);
		add_row(make_req(1999, 12, 31, 23, 59, UNIT_MINUTE, 65535), 1'b0, '0);
		add_row(make_req(65535, 15, 31, 31, 63, UNIT_MINUTE, 65535), 1'b0, '0);
		add_row(make_req(0, 0, 0, 0, 0, UNIT_DAY, 1), 1'b0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			send_req(directed_rows[k].stim, directed_rows[k].typed, directed_rows[k].want);

		// Phases: no idling, sender gaps, receiver stalls with one long
		// hold-off, then both.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 59; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 59; hold_request = 1'b1; end
				default: begin idle_pct = 34; stall_pct = 34; end
			endcase
			for (i = 0; i < ITEMS_PER_PHASE; i++)
				send_req(random_request(), 1'b0, '0);
		end

		// Drain every outstanding result with the receiver always ready.
		req_valid <= 1'b0;
		idle_pct   = 0;
		stall_pct  = 0;
		drain_wait = 0;
		while (expected_dates.size() != 0 && drain_wait < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_dates.size() != 0)
			report_fault($sformatf("%0d expected results never arrived",
				expected_dates.size()));

		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/cdt_pkg.sv
rtl/core/cdt_div.sv
rtl/core/calendar_datetime_add_top.sv
tb/tb_calendar_datetime_add_top.sv
